[hw/rtl/pdjls_pkg.sv]
`default_nettype none
package pdjls_pkg;
   localparam int LossFull = 25600;
   localparam int DefFractionBits = 8;
   localparam int DefCountWidth = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_DELAY,
      ST_DIV_JIT,
      ST_DIV_LOSS,
      ST_MEAN_LOSS,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

[hw/rtl/pdjls_if.sv]
`default_nettype none
interface pdjls_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] rx_stamp;
   logic [47:0] tx_stamp;
   logic [31:0] seq;
   logic [31:0] received_count;
   logic [31:0] peer_count;
   modport source (output valid, rx_stamp, tx_stamp, seq, received_count, peer_count,
                   input ready);
   modport sink (input valid, rx_stamp, tx_stamp, seq, received_count, peer_count,
                 output ready);
endinterface

interface pdjls_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] delay_last;
   logic signed [31:0] delay_min;
   logic signed [31:0] delay_max;
   logic signed [39:0] delay_mean;
   logic [39:0]        jitter_mean;
   logic [31:0]        jitter_min;
   logic [31:0]        jitter_max;
   logic               jitter_valid;
   logic [14:0]        loss_now;
   logic [14:0]        loss_mean;
   logic [14:0]        loss_min;
   logic [14:0]        loss_max;
   modport source (output valid, delay_last, delay_min, delay_max, delay_mean, jitter_mean,
                   jitter_min, jitter_max, jitter_valid, loss_now, loss_mean, loss_min,
                   loss_max, input ready);
   modport sink (input valid, delay_last, delay_min, delay_max, delay_mean, jitter_mean,
                 jitter_min, jitter_max, jitter_valid, loss_now, loss_mean, loss_min,
                 loss_max, output ready);
endinterface
`default_nettype wire

[hw/rtl/pdjls_div.sv]
`default_nettype none
module pdjls_div #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NumWidth-1:0] num,
   input  wire logic [DenWidth-1:0] den,
   output logic                     done,
   output logic [NumWidth-1:0]      quo
);
   localparam int CntW = $clog2(NumWidth + 1);
   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0]   shifted;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CntW'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

[hw/rtl/packet_delay_jitter_loss_stats.sv]
// Each accepted beat runs four bit-serial divisions in turn (three without a jitter sample):
// delay mean, jitter mean, loss, then loss mean; the result beat is posted after the last.
// One beat is worked on at a time: the input is held off until the result beat is taken.
// Reset (synchronous, active high) clears the counts, minima, maxima and means and the handshake state.
`default_nettype none
module packet_delay_jitter_loss_stats #(
   parameter int FRACTION_BITS = pdjls_pkg::DefFractionBits,
   parameter int COUNT_WIDTH = pdjls_pkg::DefCountWidth
) (
   input wire logic clock,
   input wire logic reset,
   pdjls_req_if.sink req,
   pdjls_rsp_if.source rsp
);
   import pdjls_pkg::*;

   localparam int DW = 64;
   localparam int EW = 66;
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
   localparam logic signed [EW-1:0] SMax = EW'((64'sd1 <<< 39) - 1);
   localparam logic signed [EW-1:0] SMin = -EW'(64'sd1 <<< 39);
   localparam logic signed [EW-1:0] UMax = EW'((64'sd1 <<< 40) - 1);

   state_type st_ff, st_in;
   logic [COUNT_WIDTH-1:0] scnt_ff, jcnt_ff;
   logic signed [31:0] dmin_ff, dmax_ff, prev_d_ff, dly_ff;
   logic [31:0] jmin_ff, jmax_ff, jit_ff, prev_seq_ff;
   logic signed [39:0] dmean_ff;
   logic [39:0] jmean_ff;
   logic [14:0] lmean_ff, lmin_ff, lmax_ff, loss_ff;
   logic first_ff, jtake_ff, neg_ff, rsp_v_ff;
   logic [31:0] snd_ff, rcv_ff;

   logic accept;
   logic signed [49:0] diff;
   logic signed [31:0] dly;
   logic [31:0] jabs;
   logic signed [EW-1:0] start_diff, mean_m, mean_res;
   logic start_neg;
   logic [DW-1:0] mag;
   logic [47:0] den;
   logic div_start, div_done;
   logic [DW-1:0] quo;
   logic signed [EW-1:0] stepv;
   logic [63:0] lnum;
   logic [COUNT_WIDTH-1:0] scnt_n, jcnt_n;
   logic [14:0] loss_q;

   assign accept = req.valid && req.ready;
   assign diff = $signed({2'b0, req.rx_stamp}) - $signed({2'b0, req.tx_stamp});
   assign dly = (diff > 50'sd2147483647) ? 32'sh7fffffff :
                (diff < -50'sd2147483648) ? 32'sh80000000 : diff[31:0];
   assign jabs = (prev_d_ff > dly) ? 32'(prev_d_ff - dly) : 32'(dly - prev_d_ff);
   assign lnum = 64'(snd_ff - rcv_ff) * 64'(LossFull);
   assign loss_q = (snd_ff != 0 && rcv_ff < snd_ff) ? quo[14:0] : 15'd0;

   always_comb begin
      case (st_ff)
         ST_IDLE: start_diff = (EW'(dly) <<< FRACTION_BITS) - EW'(dmean_ff);
         ST_DIV_DELAY: start_diff = ($signed({34'b0, jit_ff}) <<< FRACTION_BITS)
                                    - $signed({26'b0, jmean_ff});
         default: start_diff = $signed({51'b0, loss_q}) - $signed({51'b0, lmean_ff});
      endcase
      case (st_ff)
         ST_DIV_DELAY: mean_m = EW'(dmean_ff);
         ST_DIV_JIT: mean_m = $signed({26'b0, jmean_ff});
         default: mean_m = $signed({51'b0, lmean_ff});
      endcase
   end

   assign start_neg = start_diff < 0;
   assign stepv = neg_ff ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
   assign mean_res = mean_m + stepv;

   assign scnt_n = (scnt_ff == CountMax) ? scnt_ff : scnt_ff + 1'b1;
   assign jcnt_n = (jcnt_ff == CountMax) ? jcnt_ff : jcnt_ff + 1'b1;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (accept) st_in = ST_DIV_DELAY;
         ST_DIV_DELAY: if (div_done) st_in = jtake_ff ? ST_DIV_JIT : ST_DIV_LOSS;
         ST_DIV_JIT: if (div_done) st_in = ST_DIV_LOSS;
         ST_DIV_LOSS: if (div_done) st_in = ST_MEAN_LOSS;
         ST_MEAN_LOSS: if (div_done) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      mag = '0;
      den = 48'(scnt_ff);
      case (st_ff)
         ST_IDLE: begin
            div_start = accept;
            mag = 64'(start_neg ? -start_diff : start_diff);
            den = 48'(scnt_n);
         end
         ST_DIV_DELAY: begin
            div_start = div_done;
            if (jtake_ff) begin
               mag = 64'(start_neg ? -start_diff : start_diff);
               den = 48'(jcnt_ff);
            end else begin
               mag = lnum;
               den = 48'(snd_ff);
            end
         end
         ST_DIV_JIT: begin
            div_start = div_done;
            mag = lnum;
            den = 48'(snd_ff);
         end
         ST_DIV_LOSS: begin
            div_start = div_done;
            mag = 64'(start_neg ? -start_diff : start_diff);
            den = 48'(scnt_ff);
         end
         default: ;
      endcase
   end

   pdjls_div #(.NumWidth(DW), .DenWidth(48)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(mag), .den(den),
      .done(div_done), .quo(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_v_ff <= 1'b0;
         scnt_ff <= '0; jcnt_ff <= '0;
         dmin_ff <= '0; dmax_ff <= '0; dmean_ff <= '0; prev_d_ff <= '0; prev_seq_ff <= '0;
         jmean_ff <= '0; jmin_ff <= '0; jmax_ff <= '0;
         lmean_ff <= '0; lmin_ff <= '0; lmax_ff <= '0;
      end else begin
         st_ff <= st_in;
         rsp_v_ff <= (st_ff == ST_DONE) || (rsp_v_ff && !rsp.ready);
         case (st_ff)
            ST_IDLE: if (accept) begin
               first_ff <= (scnt_ff == '0);
               jtake_ff <= (scnt_ff != '0) && (req.seq - prev_seq_ff == 32'd1);
               dly_ff <= dly;
               jit_ff <= jabs;
               snd_ff <= req.peer_count;
               rcv_ff <= req.received_count;
               neg_ff <= start_neg;
               scnt_ff <= scnt_n;
               if (scnt_ff == '0 || dly < dmin_ff) dmin_ff <= dly;
               if (scnt_ff == '0 || dly > dmax_ff) dmax_ff <= dly;
               prev_d_ff <= dly;
               prev_seq_ff <= req.seq;
               if ((scnt_ff != '0) && (req.seq - prev_seq_ff == 32'd1)) begin
                  jcnt_ff <= jcnt_n;
                  if (jcnt_ff == '0 || jabs < jmin_ff) jmin_ff <= jabs;
                  if (jcnt_ff == '0 || jabs > jmax_ff) jmax_ff <= jabs;
               end
            end
            ST_DIV_DELAY: if (div_done) begin
               dmean_ff <= (mean_res > SMax) ? SMax[39:0] :
                           (mean_res < SMin) ? SMin[39:0] : mean_res[39:0];
               neg_ff <= jtake_ff && start_neg;
            end
            ST_DIV_JIT: if (div_done) begin
               jmean_ff <= (mean_res > UMax) ? UMax[39:0] :
                           (mean_res < 0) ? 40'd0 : mean_res[39:0];
               neg_ff <= 1'b0;
            end
            ST_DIV_LOSS: if (div_done) begin
               loss_ff <= loss_q;
               if (first_ff || loss_q < lmin_ff) lmin_ff <= loss_q;
               if (first_ff || loss_q > lmax_ff) lmax_ff <= loss_q;
               neg_ff <= start_neg;
            end
            ST_MEAN_LOSS: if (div_done) begin
               lmean_ff <= (mean_res > EW'(LossFull)) ? 15'(LossFull) :
                           (mean_res < 0) ? 15'd0 : mean_res[14:0];
            end
            default: ;
         endcase
      end
   end

   assign req.ready = (st_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.delay_last = dly_ff;
   assign rsp.delay_min = dmin_ff;
   assign rsp.delay_max = dmax_ff;
   assign rsp.delay_mean = dmean_ff;
   assign rsp.jitter_mean = jmean_ff;
   assign rsp.jitter_min = jmin_ff;
   assign rsp.jitter_max = jmax_ff;
   assign rsp.jitter_valid = (jcnt_ff != '0);
   assign rsp.loss_now = loss_ff;
   assign rsp.loss_mean = lmean_ff;
   assign rsp.loss_min = lmin_ff;
   assign rsp.loss_max = lmax_ff;

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.delay_min <= rsp.delay_max && rsp.loss_min <= rsp.loss_max))
      else $error("delay or loss min above max");
   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.loss_now <= 15'(LossFull)))
      else $error("loss out of range");
   a_jit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.jitter_valid) |-> (rsp.jitter_max == '0))
      else $error("jitter without sample");
endmodule
`default_nettype wire

[tb/packet_delay_jitter_loss_stats_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module packet_delay_jitter_loss_stats_tb;
   import pdjls_pkg::*;

   typedef struct packed {
      logic [47:0] rx_stamp;
      logic [47:0] tx_stamp;
      logic [31:0] seq;
      logic [31:0] received_count;
      logic [31:0] peer_count;
   } packet_type;

   typedef struct packed {
      logic signed [31:0] delay_last;
      logic signed [31:0] delay_min;
      logic signed [31:0] delay_max;
      logic signed [39:0] delay_mean;
      logic [39:0]        jitter_mean;
      logic [31:0]        jitter_min;
      logic [31:0]        jitter_max;
      logic               jitter_valid;
      logic [14:0]        loss_now;
      logic [14:0]        loss_mean;
      logic [14:0]        loss_min;
      logic [14:0]        loss_max;
   } stats_type;

   localparam longint CountMax = 64'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   failed = 1'b0;

   pdjls_req_if req ();
   pdjls_rsp_if rsp ();

   packet_delay_jitter_loss_stats dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   packet_type pending_packets[$];
   stats_type  expected_stats[$];

   // tracked statistics
   longint pkt_count, d_min, d_max, d_mean, last_delay;
   logic [31:0] prev_seq_num;
   longint jit_count, j_mean, j_min, j_max, l_mean, l_min, l_max;

   function automatic longint clampv(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint running_mean(longint m, longint x, longint n);
      return m + (x - m) / n;
   endfunction

   function automatic stats_type update_stats(packet_type p);
      stats_type s;
      bit first;
      longint dly, j, loss;
      longint rc, sc;
      first = (pkt_count == 0);
      dly = clampv(longint'({16'd0, p.rx_stamp}) - longint'({16'd0, p.tx_stamp}),
                   -64'sd2147483648, 64'sd2147483647);
      if (pkt_count < CountMax) pkt_count++;
      if (first || dly < d_min) d_min = dly;
      if (first || dly > d_max) d_max = dly;
      d_mean = clampv(running_mean(d_mean, dly * 256, pkt_count),
                      -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
      if (!first && (p.seq - prev_seq_num) == 32'd1) begin
         j = last_delay - dly;
         if (j < 0) j = -j;
         if (jit_count < CountMax) jit_count++;
         if (jit_count == 1 || j < j_min) j_min = j;
         if (jit_count == 1 || j > j_max) j_max = j;
         j_mean = clampv(running_mean(j_mean, j * 256, jit_count), 0, (64'sd1 <<< 40) - 1);
      end
      last_delay = dly;
      prev_seq_num = p.seq;
      rc = longint'({32'd0, p.received_count});
      sc = longint'({32'd0, p.peer_count});
      loss = 0;
      if (sc != 0 && rc < sc) loss = ((sc - rc) * LossFull) / sc;
      if (first || loss < l_min) l_min = loss;
      if (first || loss > l_max) l_max = loss;
      l_mean = clampv(running_mean(l_mean, loss, pkt_count), 0, LossFull);
      s.delay_last = dly[31:0];
      s.delay_min = d_min[31:0];
      s.delay_max = d_max[31:0];
      s.delay_mean = d_mean[39:0];
      s.jitter_mean = j_mean[39:0];
      s.jitter_min = j_min[31:0];
      s.jitter_max = j_max[31:0];
      s.jitter_valid = (jit_count != 0);
      s.loss_now = loss[14:0];
      s.loss_mean = l_mean[14:0];
      s.loss_min = l_min[14:0];
      s.loss_max = l_max[14:0];
      return s;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      bit took;
      int left;
      if (reset) begin
         req.valid <= 1'b0;
         burst_left <= $urandom_range(8, 1);
         gap_left <= 0;
      end else begin
         took = req.valid && req.ready;
         left = burst_left;
         if (took) begin
            expected_stats.push_back(update_stats(pending_packets.pop_front()));
            left = left - 1;
         end
         if (req.valid && !req.ready) begin
            // hold
         end else if (gap_left > 0) begin
            req.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (left <= 0) begin
            req.valid <= 1'b0;
            left = $urandom_range(8, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(400, 1);
         end else if (pending_packets.size() > 0) begin
            req.valid <= 1'b1;
            {req.rx_stamp, req.tx_stamp, req.seq, req.received_count,
             req.peer_count} <= pending_packets[0];
         end else begin
            req.valid <= 1'b0;
         end
         burst_left <= left;
      end
   end

   // receiver: stall pattern
   int rsp_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_phase <= 0;
      end else begin
         rsp_phase <= rsp_phase + 1;
         rsp.ready <= (rsp_phase % 1000 < 300) ? 1'b1 : (((rsp_phase * 7) % 11) < 5);
      end
   end

   always @(posedge clock) begin
      stats_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.delay_last, rsp.delay_min, rsp.delay_max, rsp.delay_mean,
                rsp.jitter_mean, rsp.jitter_min, rsp.jitter_max, rsp.jitter_valid,
                rsp.loss_now, rsp.loss_mean, rsp.loss_min, rsp.loss_max};
         if (expected_stats.size() == 0) begin
            $error("unexpected result beat");
            failed = 1'b1;
         end else begin
            want = expected_stats.pop_front();
            if (got.delay_last !== want.delay_last) begin
               $error("delay_last: expected %0d, got %0d", want.delay_last, got.delay_last);
               failed = 1'b1;
            end
            if (got.delay_min !== want.delay_min) begin
               $error("delay_min: expected %0d, got %0d", want.delay_min, got.delay_min);
               failed = 1'b1;
            end
            if (got.delay_max !== want.delay_max) begin
               $error("delay_max: expected %0d, got %0d", want.delay_max, got.delay_max);
               failed = 1'b1;
            end
            if (got.delay_mean !== want.delay_mean) begin
               $error("delay_mean: expected %0d, got %0d", want.delay_mean, got.delay_mean);
               failed = 1'b1;
            end
            if (got.jitter_mean !== want.jitter_mean) begin
               $error("jitter_mean: expected %0d, got %0d", want.jitter_mean, got.jitter_mean);
               failed = 1'b1;
            end
            if (got.jitter_min !== want.jitter_min) begin
               $error("jitter_min: expected %0d, got %0d", want.jitter_min, got.jitter_min);
               failed = 1'b1;
            end
            if (got.jitter_max !== want.jitter_max) begin
               $error("jitter_max: expected %0d, got %0d", want.jitter_max, got.jitter_max);
               failed = 1'b1;
            end
            if (got.jitter_valid !== want.jitter_valid) begin
               $error("jitter_valid: expected %0d, got %0d", want.jitter_valid,
                      got.jitter_valid);
               failed = 1'b1;
            end
            if (got.loss_now !== want.loss_now) begin
               $error("loss_now: expected %0d, got %0d", want.loss_now, got.loss_now);
               failed = 1'b1;
            end
            if (got.loss_mean !== want.loss_mean) begin
               $error("loss_mean: expected %0d, got %0d", want.loss_mean, got.loss_mean);
               failed = 1'b1;
            end
            if (got.loss_min !== want.loss_min) begin
               $error("loss_min: expected %0d, got %0d", want.loss_min, got.loss_min);
               failed = 1'b1;
            end
            if (got.loss_max !== want.loss_max) begin
               $error("loss_max: expected %0d, got %0d", want.loss_max, got.loss_max);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic add_packet(logic [47:0] rt, logic [47:0] st, logic [31:0] sq,
                             logic [31:0] rc, logic [31:0] sc);
      packet_type p;
      p = {rt, st, sq, rc, sc};
      pending_packets.push_back(p);
   endtask

   initial begin
      logic [31:0] sq;
      logic [47:0] base;
      logic [31:0] sc, rc;
      int mode;
      pkt_count = 0; d_min = 0; d_max = 0; d_mean = 0; last_delay = 0; prev_seq_num = 0;
      jit_count = 0; j_mean = 0; j_min = 0; j_max = 0; l_mean = 0; l_min = 0; l_max = 0;
      req.valid = 1'b0;
      {req.rx_stamp, req.tx_stamp, req.seq, req.received_count, req.peer_count} = '0;
      rsp.ready = 1'b0;

      // directed: first packet, extremes, saturation, wrap, loss corners
      add_packet(48'd1000, 48'd900, 32'd0, 32'd10, 32'd0);
      add_packet(48'd1050, 48'd900, 32'd1, 32'd10, 32'd20);
      add_packet(48'hFFFF_FFFF_FFFF, 48'd0, 32'd2, 32'd0, 32'hFFFF_FFFF);
      add_packet(48'd0, 48'hFFFF_FFFF_FFFF, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_packet(48'd5, 48'd5, 32'd7, 32'd30, 32'd20);
      add_packet(48'd12, 48'd2, 32'd8, 32'd0, 32'd1);
      add_packet(48'd12, 48'd2, 32'hFFFF_FFFF, 32'd1, 32'd3);
      add_packet(48'd20, 48'd2, 32'd0, 32'd2, 32'd3);
      add_packet(48'h8000_0000, 48'd0, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      add_packet(48'd0, 48'h8000_0001, 32'd2, 32'd1, 32'd2);
      add_packet(48'd0, 48'h8000_0000, 32'd2, 32'hAAAA_AAAA, 32'h5555_5555);
      add_packet(48'h5555_5555_5555, 48'h5555_5555_0000, 32'h5555_5555,
                 32'h5555_5555, 32'hAAAA_AAAA);
      add_packet(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_0000, 32'hAAAA_AAAA,
                 32'd7, 32'd9);

      // random: mostly consecutive flows, some jumps and wild timestamps
      sq = $urandom();
      base = rand48();
      sc = 0;
      rc = 0;
      repeat (850) begin
         mode = $urandom_range(9, 0);
         sq = (mode < 7) ? sq + 1 : $urandom();
         sc = sc + $urandom_range(3, 0);
         rc = rc + $urandom_range(2, 0);
         if (mode == 9) begin
            add_packet(rand48(), rand48(), sq, $urandom(), $urandom());
         end else begin
            base = base + $urandom_range(100, 0);
            add_packet(base + $urandom_range(500, 0) - ((mode == 8) ? 1000 : 0), base, sq,
                       ($urandom_range(7, 0) == 0) ? $urandom() : rc,
                       ($urandom_range(15, 0) == 0) ? 32'd0 : sc);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_packets.size() == 0);
      wait (expected_stats.size() == 0);
      repeat (300) @(posedge clock);
      if (!failed) begin
         $display("** packet_delay_jitter_loss_stats: PASSED **");
      end else begin
         $display("** packet_delay_jitter_loss_stats: FAILED **");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("** packet_delay_jitter_loss_stats: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
